// ===== hdl/tkfs_pkg.sv =====
// Package for the top-k fitness selection block.
// Holds the payload structs of the input and result channels and the configuration type.
// It has no dependencies.
package tkfs_pkg;

  localparam int FIELD_FIT_W = 16;
  localparam int FIELD_IDX_W = 8;
  localparam int POOL_CFG_W  = 7;

  typedef struct packed {
    logic [FIELD_FIT_W-1:0] fitness;
    logic                   last;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_IDX_W-1:0] member_index;
    logic [FIELD_FIT_W-1:0] member_fitness;
    logic                   final_res;
  } out_item_t;

  typedef logic [POOL_CFG_W-1:0] pool_cfg_t;

endpackage

// ===== hdl/top_k_fitness_select.sv =====
// Top-k fitness selection: a sorted pool in block memory, insertion by read-shift-write.
// A member goes straight into an empty pool, or is not inserted past the population limit; else
// the held entries are scanned from the tail, one per cycle on the single read port, each smaller
// one shifted down, with a head write (ST_PLACE) when it takes the head. A last item then issues
// each result by a read (ST_ISSUE) and an output (ST_WAIT), which an output stall can hold. Reset
// (rst_n, synchronous, active low) empties the pool and sets pool_r to 8. Depends on tkfs_pkg.
module top_k_fitness_select #(
  parameter int MAX_POOL       = 64,
  parameter int MAX_POPULATION = 256,
  parameter int FITNESS_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tkfs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tkfs_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  tkfs_pkg::pool_cfg_t cfg_data
);
  import tkfs_pkg::*;

  localparam int FB = (FITNESS_BITS < FIELD_FIT_W) ? FITNESS_BITS : FIELD_FIT_W;
  localparam int AW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int HW = $clog2(MAX_POOL + 1);
  localparam int CW = $clog2(MAX_POPULATION + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POOL - 1);
  localparam logic [HW-1:0] POOL_FULL = HW'(MAX_POOL);
  localparam logic [CW-1:0] POP_MAX   = CW'(MAX_POPULATION);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_PLACE = 5'b00100,
    ST_ISSUE = 5'b01000,
    ST_WAIT  = 5'b10000
  } state_t;

  logic [FB-1:0]          mem_fit [MAX_POOL];
  logic [FIELD_IDX_W-1:0] mem_idx [MAX_POOL];

  state_t                 state_r, state_nxt;
  logic [FB-1:0]          fit_r, fit_nxt;
  logic [FIELD_IDX_W-1:0] idx_r, idx_nxt;
  logic                   last_r, last_nxt;
  logic [AW-1:0]          j_r, j_nxt;
  logic [HW-1:0]          held_r, held_nxt;
  logic [CW-1:0]          arr_r, arr_nxt;
  logic [HW-1:0]          k_r, k_nxt;
  pool_cfg_t              pool_r, pool_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  logic [FB-1:0]          rd_fit_q;
  logic [FIELD_IDX_W-1:0] rd_idx_q;
  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [FB-1:0]          wr_fit;
  logic [FIELD_IDX_W-1:0] wr_idx;

  logic                   accept, out_free, done;
  logic [HW-1:0]          limit, n_emit;
  logic [AW-1:0]          start_addr;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    limit  = (pool_r > POOL_CFG_W'(MAX_POOL)) ? POOL_FULL : HW'(pool_r);
    n_emit = (held_r < limit) ? held_r : limit;
    start_addr = (held_r == POOL_FULL) ? LAST_ADDR : AW'(held_r - HW'(1));
  end

  always_comb begin
    state_nxt     = state_r;
    fit_nxt       = fit_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    j_nxt         = j_r;
    held_nxt      = held_r;
    arr_nxt       = arr_r;
    k_nxt         = k_r;
    pool_nxt      = cfg_valid ? cfg_data : pool_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = j_r;
    wr_en         = 1'b0;
    wr_addr       = j_r;
    wr_fit        = fit_r;
    wr_idx        = idx_r;
    done          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          fit_nxt  = in_data.fitness[FB-1:0];
          idx_nxt  = FIELD_IDX_W'(arr_r);
          last_nxt = in_data.last;
          if (arr_r < POP_MAX) begin
            arr_nxt = arr_r + CW'(1);
            if (held_r == '0) begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_fit    = in_data.fitness[FB-1:0];
              wr_idx    = FIELD_IDX_W'(arr_r);
              held_nxt  = HW'(1);
              state_nxt = in_data.last ? ST_ISSUE : ST_IDLE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = start_addr;
              j_nxt     = start_addr;
              state_nxt = ST_SCAN;
            end
          end else begin
            state_nxt = in_data.last ? ST_ISSUE : ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (rd_fit_q < fit_r) begin
          if (j_r != LAST_ADDR) begin
            wr_en   = 1'b1;
            wr_addr = j_r + AW'(1);
            wr_fit  = rd_fit_q;
            wr_idx  = rd_idx_q;
          end
          if (j_r == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = j_r - AW'(1);
            j_nxt   = j_r - AW'(1);
          end
        end else begin
          if (j_r != LAST_ADDR) begin
            wr_en   = 1'b1;
            wr_addr = j_r + AW'(1);
          end
          done = 1'b1;
        end
      end
      ST_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        done    = 1'b1;
      end
      ST_ISSUE: begin
        if (n_emit == '0) begin
          held_nxt  = '0;
          arr_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(k_r);
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.member_index   = rd_idx_q;
          out_nxt.member_fitness = FIELD_FIT_W'(rd_fit_q);
          out_nxt.final_res      = (k_r + HW'(1) == n_emit);
          if (k_r + HW'(1) == n_emit) begin
            k_nxt     = '0;
            held_nxt  = '0;
            arr_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + HW'(1);
            state_nxt = ST_ISSUE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (done) begin
      if (held_r < POOL_FULL) begin
        held_nxt = held_r + HW'(1);
      end
      state_nxt = last_r ? ST_ISSUE : ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_fit[wr_addr] <= wr_fit;
      mem_idx[wr_addr] <= wr_idx;
    end
    if (rd_en) begin
      rd_fit_q <= mem_fit[rd_addr];
      rd_idx_q <= mem_idx[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      arr_r       <= '0;
      k_r         <= '0;
      pool_r      <= pool_cfg_t'(8);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      arr_r       <= arr_nxt;
      k_r         <= k_nxt;
      pool_r      <= pool_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fit_r  <= fit_nxt;
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
    j_r    <= j_nxt;
    out_r  <= out_nxt;
  end

endmodule
